// ===== rtl/e2c_pkg.sv =====
// Shared constants, reciprocal factors and calendar helpers for the epoch converter.
`default_nettype none

package e2c_pkg;

    // Stages from input register to output register
    localparam int NUM_STAGES = 8;
    // Stages that belong to the date path (the last five)
    localparam int DATE_STAGES = 5;

    localparam int DAY_SECONDS     = 24 * 60 * 60;
    localparam int SECS_PER_HOUR   = 3600;
    localparam int SECS_PER_MINUTE = 60;
    localparam int DAYS_PER_YEAR   = 365;
    localparam int DAYS_PER_WEEK   = 7;
    localparam int EPOCH_YEAR      = 70;    // 1970 as years since 1900
    localparam int EPOCH_WEEKDAY   = 4;     // 1970-01-01 was a Thursday
    localparam int LEAP_BIAS       = 17;    // leap-day count of the years up to 1969
    localparam int NO_LEAP_YEAR    = 200;   // 2100 breaks the four-year rule
    localparam int LATE_CENTURY    = 201;   // from 2101 on, 2100 adds no leap day

    // (x * RECIP) >> SHIFT is floor(x / d) over the used range; DAY may be one low
    localparam logic [31:0] DAY_RECIP   = 32'd3257812230;
    localparam int          DAY_SHIFT   = 48;
    localparam logic [15:0] HOUR_RECIP  = 16'd37283;
    localparam int          HOUR_SHIFT  = 27;
    localparam logic [12:0] MIN_RECIP   = 13'd4370;
    localparam int          MIN_SHIFT   = 18;
    localparam logic [16:0] YEAR_RECIP  = 17'd91931;
    localparam int          YEAR_SHIFT  = 25;
    localparam logic [16:0] WEEK_RECIP  = 17'd74899;
    localparam int          WEEK_SHIFT  = 19;

    typedef logic [15:0] day_count_t;
    typedef logic [8:0]  yday_t;
    typedef logic [7:0]  year_t;
    typedef logic [3:0]  month_t;

    // Zero-based first day of each month
    function automatic yday_t month_start(input logic leap, input month_t idx);
        yday_t base;
        case (idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && (idx >= 4'd2) && (idx <= 4'd11))
        begin
            base = base + 9'd1;
        end
        return base;
    endfunction

    // Gregorian leap rule for years 1969..2106 given as years since 1900
    function automatic logic year_is_leap(input year_t y);
        return (y[1:0] == 2'b00) && (y != 8'(NO_LEAP_YEAR));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/e2c_in_if.sv =====
// Input channel: one epoch timestamp per beat.
`default_nettype none

interface e2c_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

`default_nettype wire

// ===== rtl/e2c_out_if.sv =====
// Output channel: one broken-down calendar record per beat.
`default_nettype none

interface e2c_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] year_since_1900;
    logic [8:0] day_of_year;
    logic [3:0] month_index;
    logic [4:0] day_of_month;
    logic [2:0] weekday;
    logic [4:0] hour_of_day;
    logic [5:0] minute_of_hour;
    logic [5:0] second_of_minute;

    modport source (output valid, output year_since_1900, output day_of_year,
                    output month_index, output day_of_month, output weekday,
                    output hour_of_day, output minute_of_hour, output second_of_minute,
                    input ready);
    modport sink   (input valid, input year_since_1900, input day_of_year,
                    input month_index, input day_of_month, input weekday,
                    input hour_of_day, input minute_of_hour, input second_of_minute,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/e2c_date.sv =====
// Date path: day count to year, day of year, month, day of month and weekday.
`default_nettype none

module e2c_date (
    input  wire logic                                clk,
    input  wire logic [e2c_pkg::DATE_STAGES-1:0]     en,
    input  wire e2c_pkg::day_count_t                 days,
    output e2c_pkg::year_t                           year,
    output e2c_pkg::yday_t                           yday,
    output e2c_pkg::month_t                          month,
    output logic [4:0]                               mday,
    output logic [2:0]                               wday
);
    import e2c_pkg::*;

    // Stage A: reciprocal multiplies for /365 and /7
    logic [32:0]  yprod;
    logic [33:0]  wprod;
    logic [16:0]  days_plus;
    year_t        yq_reg;
    logic [13:0]  wq_reg;
    day_count_t   days_a_reg;

    // Stage B: remainders
    logic [15:0]  ymod_full;
    logic [16:0]  wmod_full;
    yday_t        ymod_reg;
    year_t        year_b_reg;
    logic [2:0]   wday_b_reg;

    // Stage C: take off earlier leap days
    year_t        year_m1;
    logic [6:0]   leap_before;
    logic [9:0]   yday_c_next;
    logic [9:0]   yday_c_reg;
    year_t        year_c_reg;
    logic [2:0]   wday_c_reg;

    // Stage D: step back one year on underflow
    year_t        year_d_next;
    yday_t        yday_d_next;
    year_t        year_d_reg;
    yday_t        yday_d_reg;
    logic         leap_d_reg;
    logic [2:0]   wday_d_reg;

    // Stage E: month search
    month_t       month_e_next;
    logic [4:0]   mday_e_next;
    year_t        year_e_reg;
    yday_t        yday_e_reg;
    month_t       month_e_reg;
    logic [4:0]   mday_e_reg;
    logic [2:0]   wday_e_reg;

    always_comb
    begin
        days_plus = 17'(days) + 17'(EPOCH_WEEKDAY);
        yprod     = 33'(days) * 33'(YEAR_RECIP);
        wprod     = 34'(days_plus) * 34'(WEEK_RECIP);
    end

    always_comb
    begin
        ymod_full = days_a_reg - 16'(yq_reg) * 16'(DAYS_PER_YEAR);
        wmod_full = (17'(days_a_reg) + 17'(EPOCH_WEEKDAY)) - 17'(wq_reg) * 17'(DAYS_PER_WEEK);
    end

    always_comb
    begin
        year_m1     = year_b_reg - 8'd1;
        leap_before = 7'(year_m1[7:2]) - 7'(LEAP_BIAS)
                      - ((year_b_reg >= 8'(LATE_CENTURY)) ? 7'd1 : 7'd0);
        yday_c_next = 10'(ymod_reg) - 10'(leap_before);
    end

    always_comb
    begin
        if (yday_c_reg[9])
        begin
            year_d_next = year_c_reg - 8'd1;
            yday_d_next = 9'(yday_c_reg + 10'(DAYS_PER_YEAR)
                          + (year_is_leap(year_c_reg - 8'd1) ? 10'd1 : 10'd0));
        end
        else
        begin
            year_d_next = year_c_reg;
            yday_d_next = yday_c_reg[8:0];
        end
    end

    // Month tables are monotone: the last start not past the day wins
    always_comb
    begin
        month_e_next = '0;
        for (int k = 1; k < 12; k++)
        begin
            if (yday_d_reg >= month_start(leap_d_reg, 4'(k)))
            begin
                month_e_next = 4'(k);
            end
        end
        mday_e_next = 5'(yday_d_reg - month_start(leap_d_reg, month_e_next) + 9'd1);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            yq_reg     <= yprod[YEAR_SHIFT+7:YEAR_SHIFT];
            wq_reg     <= wprod[WEEK_SHIFT+13:WEEK_SHIFT];
            days_a_reg <= days;
        end
        if (en[1])
        begin
            ymod_reg   <= ymod_full[8:0];
            year_b_reg <= yq_reg + 8'(EPOCH_YEAR);
            wday_b_reg <= wmod_full[2:0];
        end
        if (en[2])
        begin
            yday_c_reg <= yday_c_next;
            year_c_reg <= year_b_reg;
            wday_c_reg <= wday_b_reg;
        end
        if (en[3])
        begin
            year_d_reg <= year_d_next;
            yday_d_reg <= yday_d_next;
            leap_d_reg <= year_is_leap(year_d_next);
            wday_d_reg <= wday_c_reg;
        end
        if (en[4])
        begin
            year_e_reg  <= year_d_reg;
            yday_e_reg  <= yday_d_reg;
            month_e_reg <= month_e_next;
            mday_e_reg  <= mday_e_next;
            wday_e_reg  <= wday_d_reg;
        end
    end

    assign year  = year_e_reg;
    assign yday  = yday_e_reg;
    assign month = month_e_reg;
    assign mday  = mday_e_reg;
    assign wday  = wday_e_reg;

endmodule

`default_nettype wire

// ===== rtl/epoch_seconds_to_calendar_core.sv =====
// Top level: pipelined conversion of Unix epoch seconds to UTC calendar fields.
`default_nettype none

// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 UTC
// into Gregorian UTC calendar fields (year since 1900, day of year, month,
// day of month, weekday, hour, minute, second). Every 32-bit value is a valid
// time; the largest one is 2106-02-07 06:28:15. Throughput is one beat per
// clock while the output takes results; there are eight register stages,
// stage 0 through stage 7, and stage 7 is the output register.
// That depth is set by the chain of constant-reciprocal multiplies (seconds to
// days, days to years and weekdays, seconds of day to hours and minutes),
// each followed by a register before its remainder is formed. Each stage has
// a valid bit and stalls only while it is full and the stage after it cannot
// take its contents, so bubbles are squeezed out under back-pressure and the
// input keeps taking beats while a result waits, until no stage is empty.
// There is no configuration and no memory; reset only clears the valid bits.

module epoch_seconds_to_calendar_core (
    input wire logic clk,
    input wire logic rst_n,
    e2c_in_if.sink   epoch,
    e2c_out_if.source calendar
);
    import e2c_pkg::*;

    // Per-stage valid bits and advance enables; adv[i] lets stage i load
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES:0]   adv;

    // Stage 0: reciprocal multiply for the day count
    logic [63:0]  day_prod;
    day_count_t   q0_reg;
    logic [31:0]  t0_reg;

    // Stage 1: remainder against the estimate
    logic [31:0]  rem_full;
    day_count_t   q1_reg;
    logic [17:0]  r1_reg;

    // Stage 2: correct an estimate that came out one low
    day_count_t   days2_next;
    logic [16:0]  sod2_next;
    day_count_t   days2_reg;
    logic [16:0]  sod2_reg;

    // Time-of-day path
    logic [32:0]  hour_prod;
    logic [4:0]   hour3_reg;
    logic [16:0]  sod3_reg;
    logic [16:0]  remh_full;
    logic [4:0]   hour4_reg;
    logic [11:0]  remh4_reg;
    logic [24:0]  min_prod;
    logic [4:0]   hour5_reg;
    logic [5:0]   min5_reg;
    logic [11:0]  remh5_reg;
    logic [11:0]  sec_full;
    logic [4:0]   hour6_reg;
    logic [5:0]   min6_reg;
    logic [5:0]   sec6_reg;
    logic [4:0]   hour7_reg;
    logic [5:0]   min7_reg;
    logic [5:0]   sec7_reg;

    always_comb
    begin
        adv[NUM_STAGES] = calendar.ready;
        for (int i = NUM_STAGES - 1; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign epoch.ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= epoch.valid;
            end
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Day split: estimate is exact or one low, so one compare-subtract fixes it
    always_comb
    begin
        day_prod = 64'(epoch.epoch_seconds) * 64'(DAY_RECIP);
        rem_full = t0_reg - 32'(q0_reg) * 32'(DAY_SECONDS);
        if (r1_reg >= 18'(DAY_SECONDS))
        begin
            days2_next = q1_reg + 16'd1;
            sod2_next  = 17'(r1_reg - 18'(DAY_SECONDS));
        end
        else
        begin
            days2_next = q1_reg;
            sod2_next  = r1_reg[16:0];
        end
    end

    // Seconds of day to hour, minute, second
    always_comb
    begin
        hour_prod = 33'(sod2_reg) * 33'(HOUR_RECIP);
        remh_full = sod3_reg - 17'(hour3_reg) * 17'(SECS_PER_HOUR);
        min_prod  = 25'(remh4_reg) * 25'(MIN_RECIP);
        sec_full  = remh5_reg - 12'(min5_reg) * 12'(SECS_PER_MINUTE);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            q0_reg <= day_prod[DAY_SHIFT+15:DAY_SHIFT];
            t0_reg <= epoch.epoch_seconds;
        end
        if (adv[1])
        begin
            q1_reg <= q0_reg;
            r1_reg <= rem_full[17:0];
        end
        if (adv[2])
        begin
            days2_reg <= days2_next;
            sod2_reg  <= sod2_next;
        end
        if (adv[3])
        begin
            hour3_reg <= hour_prod[HOUR_SHIFT+4:HOUR_SHIFT];
            sod3_reg  <= sod2_reg;
        end
        if (adv[4])
        begin
            hour4_reg <= hour3_reg;
            remh4_reg <= remh_full[11:0];
        end
        if (adv[5])
        begin
            hour5_reg <= hour4_reg;
            min5_reg  <= min_prod[MIN_SHIFT+5:MIN_SHIFT];
            remh5_reg <= remh4_reg;
        end
        if (adv[6])
        begin
            hour6_reg <= hour5_reg;
            min6_reg  <= min5_reg;
            sec6_reg  <= sec_full[5:0];
        end
        if (adv[7])
        begin
            hour7_reg <= hour6_reg;
            min7_reg  <= min6_reg;
            sec7_reg  <= sec6_reg;
        end
    end

    // Date path runs alongside stages 3..7
    e2c_date u_date (
        .clk   (clk),
        .en    (adv[NUM_STAGES-1:NUM_STAGES-DATE_STAGES]),
        .days  (days2_reg),
        .year  (calendar.year_since_1900),
        .yday  (calendar.day_of_year),
        .month (calendar.month_index),
        .mday  (calendar.day_of_month),
        .wday  (calendar.weekday)
    );

    assign calendar.valid            = vld_reg[NUM_STAGES-1];
    assign calendar.hour_of_day      = hour7_reg;
    assign calendar.minute_of_hour   = min7_reg;
    assign calendar.second_of_minute = sec7_reg;

endmodule

`default_nettype wire
